>>> sv/ubsd_pkg.sv
// Shared types and constants for the UTF-16 byte stream decoder.
// No dependencies; every other source file uses this package.
package ubsd_pkg;

	localparam int CP_W = 21;
	localparam int SURR_W = 10;

	localparam logic [7:0] HS_MIN = 8'hD8;
	localparam logic [7:0] HS_MAX = 8'hDB;
	localparam logic [7:0] LS_MIN = 8'hDC;
	localparam logic [7:0] LS_MAX = 8'hDF;
	localparam logic [7:0] BOM_FE = 8'hFE;
	localparam logic [7:0] BOM_FF = 8'hFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
	localparam logic [CP_W-1:0] ASCII_MAX = 21'h7F;

	// one paired unit (or a bare end-of-string marker) on its way to the back end
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic       has_unit;
		logic       last;
		logic       bom_be;
		logic       bom_le;
	} ubsd_unit_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ubsd_q_status_t;

endpackage

>>> sv/ubsd_if.sv
// Handshake channels of the decoder: input bytes, decoded code points, config writes.
// Depends on ubsd_pkg for the code point width.
interface ubsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ubsd_cp_if;
	logic                      valid;
	logic                      ready;
	logic [ubsd_pkg::CP_W-1:0] code_point;
	logic                      is_ascii;
	logic                      is_error;

	modport source (output valid, output code_point, output is_ascii, output is_error,
		input ready);
	modport sink (input valid, input code_point, input is_ascii, input is_error,
		output ready);
endinterface

interface ubsd_cfg_if;
	logic valid;
	logic ready;
	logic default_big_endian;

	modport source (output valid, output default_big_endian, input ready);
	modport sink (input valid, input default_big_endian, output ready);
endinterface

>>> sv/utf16_byte_stream_decoder.sv
// UTF-16 byte stream decoder: one byte per cycle in while the unit queue has room,
// at most one code point per unit out. A result passes through the unit queue and
// then the output register, which holds it while the output is stalled.
// Throughput: 1 byte per cycle unless a stalled output fills the unit queue.
// Reset clears pairing, surrogate and queue state; byte order resets to big endian.
// Depends on ubsd_pkg, ubsd_if, ubsd_front, ubsd_queue and ubsd_back.
module utf16_byte_stream_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	ubsd_byte_if.sink bytes,
	ubsd_cp_if.source points,
	ubsd_cfg_if.sink  cfg
);
	import ubsd_pkg::*;

	ubsd_unit_t     wr_item;
	ubsd_unit_t     rd_item;
	ubsd_q_status_t qstat;
	logic           push;
	logic           pop;

	ubsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.qstat  (qstat),
		.push   (push),
		.item   (wr_item)
	);

	ubsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.status  (qstat)
	);

	ubsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (rd_item),
		.qstat  (qstat),
		.pop    (pop),
		.points (points),
		.cfg    (cfg)
	);

endmodule

>>> sv/ubsd_front.sv
// Front end: accepts bytes, pairs them into units and spots byte order marks.
// Depends on ubsd_pkg and ubsd_byte_if.
module ubsd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	ubsd_byte_if.sink                bytes,
	input  ubsd_pkg::ubsd_q_status_t qstat,
	output logic                     push,
	output ubsd_pkg::ubsd_unit_t     item
);
	import ubsd_pkg::*;

	logic       have_first_q;
	logic [7:0] first_q;
	logic       accept;

	assign bytes.ready = !qstat.full;
	assign accept = bytes.valid && bytes.ready;

	// forward on the second byte of a unit, or on a last byte to flush the back end
	assign push = accept && (have_first_q || bytes.last_byte);

	always_comb begin
		item.b0 = first_q;
		item.b1 = bytes.data_byte;
		item.has_unit = have_first_q;
		item.last = bytes.last_byte;
		item.bom_be = (first_q == BOM_FE) && (bytes.data_byte == BOM_FF);
		item.bom_le = (first_q == BOM_FF) && (bytes.data_byte == BOM_FE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
		end else if (accept) begin
			have_first_q <= !have_first_q && !bytes.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !have_first_q) begin
			first_q <= bytes.data_byte;
		end
	end

endmodule

>>> sv/ubsd_queue.sv
// Short register queue between the front and back ends.
// Depends on ubsd_pkg for the item and status types.
module ubsd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  ubsd_pkg::ubsd_unit_t     wr_item,
	input  logic                     pop,
	output ubsd_pkg::ubsd_unit_t     rd_item,
	output ubsd_pkg::ubsd_q_status_t status
);
	import ubsd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ubsd_unit_t      slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign status.full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign rd_item = slots_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("item pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(status.empty || status.full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

>>> sv/ubsd_back.sv
// Back end: applies byte order, joins surrogate pairs and holds the result register.
// Depends on ubsd_pkg, ubsd_cp_if and ubsd_cfg_if.
module ubsd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ubsd_pkg::ubsd_unit_t     item,
	input  ubsd_pkg::ubsd_q_status_t qstat,
	output logic                     pop,
	ubsd_cp_if.source                points,
	ubsd_cfg_if.sink                 cfg
);
	import ubsd_pkg::*;

	logic              big_endian_q;
	logic              have_hs_q;
	logic [SURR_W-1:0] hs_bits_q;
	logic              out_valid_q;
	logic [CP_W-1:0]   cp_q;
	logic              ascii_q;
	logic              error_q;

	logic              is_bom;
	logic [7:0]        hi;
	logic [7:0]        lo;
	logic              hi_is_hs;
	logic              hi_is_ls;
	logic              emit;
	logic [CP_W-1:0]   emit_cp;
	logic              emit_err;
	logic [CP_W-1:0]   pair_cp;

	assign cfg.ready = 1'b1;
	assign pop = !qstat.empty && (!out_valid_q || points.ready);

	assign points.valid = out_valid_q;
	assign points.code_point = cp_q;
	assign points.is_ascii = ascii_q;
	assign points.is_error = error_q;

	// a mark right after a high surrogate is just a broken partner
	assign is_bom = item.has_unit && !have_hs_q && (item.bom_be || item.bom_le);
	assign hi = big_endian_q ? item.b0 : item.b1;
	assign lo = big_endian_q ? item.b1 : item.b0;
	assign hi_is_hs = (hi >= HS_MIN) && (hi <= HS_MAX);
	assign hi_is_ls = (hi >= LS_MIN) && (hi <= LS_MAX);
	assign pair_cp = SUPP_BASE + {1'b0, hs_bits_q, hi[1:0], lo};

	always_comb begin
		emit = 1'b0;
		emit_cp = '0;
		emit_err = 1'b0;
		if (item.has_unit && !is_bom) begin
			if (have_hs_q) begin
				emit = 1'b1;
				emit_cp = hi_is_ls ? pair_cp : '0;
				emit_err = !hi_is_ls;
			end else if (!hi_is_hs) begin
				emit = 1'b1;
				emit_cp = {5'd0, hi, lo};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			have_hs_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				big_endian_q <= cfg.default_big_endian;
			end else if (pop && is_bom) begin
				big_endian_q <= item.bom_be;
			end
			if (pop) begin
				if (item.last) begin
					have_hs_q <= 1'b0;
				end else if (item.has_unit && !is_bom) begin
					have_hs_q <= !have_hs_q && hi_is_hs;
				end
				out_valid_q <= emit;
			end else if (points.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.has_unit && !is_bom && !have_hs_q && hi_is_hs) begin
			hs_bits_q <= {hi[1:0], lo};
		end
		if (pop && emit) begin
			cp_q <= emit_cp;
			ascii_q <= !emit_err && (emit_cp <= ASCII_MAX);
			error_q <= emit_err;
		end
	end

	a_last_clears_hs: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> !have_hs_q)
		else $error("held surrogate survived end of string");

	a_error_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && error_q) |-> (cp_q == '0 && !ascii_q))
		else $error("error result carries a code point");

	a_pair_consumes_hs: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && have_hs_q && item.has_unit) |=> !have_hs_q)
		else $error("surrogate still held after its partner");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !points.ready) |-> !pop)
		else $error("item taken while result is stalled");

endmodule

>>> tb/utf16_byte_stream_decoder_tb.sv
// Self-checking testbench for utf16_byte_stream_decoder: directed and random UTF-16 byte
// streams, a predictor of the decoded code points, random idling on both channels.
// Depends on ubsd_pkg, the ubsd_if interfaces and the decoder RTL.
module utf16_byte_stream_decoder_tb;
	import ubsd_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES = 220;
	localparam int N_PHASES = 6;
	localparam int N_DIRECTED = 27;

	// {last_byte, data_byte}, starting in big endian
	localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
		9'h000, 9'h07F,                 // ASCII maximum
		9'h0FF, 9'h0FF,                 // all-ones unit, not a mark
		9'h0DB, 9'h0FF, 9'h0DF, 9'h0FF, // highest supplementary code point
		9'h0D8, 9'h000, 9'h0FE, 9'h0FF, // mark right after a high surrogate
		9'h0DC, 9'h000,                 // lone low surrogate
		9'h0FF, 9'h0FE,                 // switch to little endian
		9'h000, 9'h0D8, 9'h000, 9'h0DC, // little endian pair
		9'h0FE, 9'h0FF,                 // back to big endian
		9'h180,                         // last on a half unit
		9'h0D8, 9'h100,                 // last on a held high surrogate
		9'h0DC, 9'h000
	};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_ascii;
		logic            is_error;
	} cp_result_t;

	typedef enum int {
		K_ASCII, K_BMP, K_PAIR, K_LONE_LOW, K_BROKEN, K_MARK
	} unit_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ubsd_byte_if byte_ch ();
	ubsd_cp_if   cp_ch ();
	ubsd_cfg_if  cfg_ch ();

	logic       drv_valid = 1'b0;
	logic [7:0] drv_data = 8'h00;
	logic       drv_last = 1'b0;
	logic       rcv_ready = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_value = 1'b1;

	assign byte_ch.valid = drv_valid;
	assign byte_ch.data_byte = drv_data;
	assign byte_ch.last_byte = drv_last;
	assign cp_ch.ready = rcv_ready;
	assign cfg_ch.valid = cfg_valid;
	assign cfg_ch.default_big_endian = cfg_value;

	utf16_byte_stream_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.points (cp_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// decoder state as predicted
	logic       ord_be = 1'b1;
	logic       half_valid = 1'b0;
	logic [7:0] half_byte = 8'h00;
	logic       hs_valid = 1'b0;
	logic [9:0] hs_bits = 10'h000;

	byte_item_t byte_backlog [$];
	cp_result_t cp_expected [$];
	logic [7:0] str_bytes [$];
	logic       gen_be;

	byte_item_t cur_item;
	logic       drv_busy = 1'b0;
	int         gap_left = 0;
	bit         send_idle_on = 1'b1;
	bit         recv_idle_on = 1'b1;
	bit         hold_req = 1'b0;
	bit         hold_taken = 1'b0;
	int         hold_left = 0;
	int         recv_wait = 0;
	int         fail_count = 0;
	int         idle_cycles = 0;

	function automatic int draw_wait(input bit enabled);
		if (!enabled || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	task automatic emit_point(input logic [CP_W-1:0] cp, input logic err);
		cp_result_t r;
		r.code_point = err ? '0 : cp;
		r.is_ascii = !err && (cp <= ASCII_MAX);
		r.is_error = err;
		cp_expected.push_back(r);
	endtask

	task automatic decode_unit(input logic [7:0] b0, input logic [7:0] b1);
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [15:0] unit;
		if (!hs_valid && b0 == BOM_FE && b1 == BOM_FF) begin
			ord_be = 1'b1;
		end else if (!hs_valid && b0 == BOM_FF && b1 == BOM_FE) begin
			ord_be = 1'b0;
		end else begin
			hi = ord_be ? b0 : b1;
			lo = ord_be ? b1 : b0;
			unit = {hi, lo};
			if (hs_valid) begin
				// the unit after a held high surrogate is always its partner
				hs_valid = 1'b0;
				if (hi >= LS_MIN && hi <= LS_MAX)
					emit_point(SUPP_BASE + {hs_bits, unit[9:0]}, 1'b0);
				else
					emit_point('0, 1'b1);
				hs_bits = '0;
			end else if (hi >= HS_MIN && hi <= HS_MAX) begin
				hs_valid = 1'b1;
				hs_bits = unit[9:0];
			end else begin
				emit_point({5'b0, unit}, 1'b0);
			end
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		if (half_valid) begin
			half_valid = 1'b0;
			decode_unit(half_byte, b);
			half_byte = '0;
		end else begin
			half_valid = 1'b1;
			half_byte = b;
		end
		// drop partial state, keep the byte order
		if (last) begin
			half_valid = 1'b0;
			half_byte = '0;
			hs_valid = 1'b0;
			hs_bits = '0;
		end
	endtask

	// driver: one item from the backlog at a time, random gap before each
	always @(posedge clk) begin
		if (arst_n) begin
			if (drv_valid && byte_ch.ready) begin
				decode_byte(cur_item.data, cur_item.last);
				gap_left = draw_wait(send_idle_on);
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_backlog.size() != 0) begin
					cur_item = byte_backlog.pop_front();
					drv_busy = 1'b1;
				end
			end
		end
		drv_valid <= drv_busy;
		drv_data <= cur_item.data;
		drv_last <= cur_item.last;
	end

	// monitor: check each code point, then stall ready at random
	always @(posedge clk) begin
		cp_result_t want;
		if (cp_ch.valid && rcv_ready) begin
			if (cp_expected.size() == 0) begin
				$error("unexpected item: code_point %h is_ascii %b is_error %b",
					cp_ch.code_point, cp_ch.is_ascii, cp_ch.is_error);
				fail_count++;
			end else begin
				want = cp_expected.pop_front();
				if (cp_ch.code_point !== want.code_point) begin
					$error("code_point mismatch: expected %h, actual %h",
						want.code_point, cp_ch.code_point);
					fail_count++;
				end
				if (cp_ch.is_ascii !== want.is_ascii) begin
					$error("is_ascii mismatch: expected %b, actual %b",
						want.is_ascii, cp_ch.is_ascii);
					fail_count++;
				end
				if (cp_ch.is_error !== want.is_error) begin
					$error("is_error mismatch: expected %b, actual %b",
						want.is_error, cp_ch.is_error);
					fail_count++;
				end
			end
			recv_wait = draw_wait(recv_idle_on);
		end
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rcv_ready <= 1'b0;
		end else if (recv_wait > 0) begin
			recv_wait--;
			rcv_ready <= 1'b0;
		end else begin
			rcv_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((drv_valid && byte_ch.ready) || (cp_ch.valid && rcv_ready)
				|| (cfg_valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("utf16_byte_stream_decoder verification failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		byte_item_t it;
		it.data = b;
		it.last = last;
		byte_backlog.push_back(it);
	endtask

	task automatic put_unit(input logic [15:0] u);
		if (gen_be) begin
			str_bytes.push_back(u[15:8]);
			str_bytes.push_back(u[7:0]);
		end else begin
			str_bytes.push_back(u[7:0]);
			str_bytes.push_back(u[15:8]);
		end
	endtask

	task automatic put_mark(input logic be);
		str_bytes.push_back(be ? BOM_FE : BOM_FF);
		str_bytes.push_back(be ? BOM_FF : BOM_FE);
	endtask

	function automatic logic [15:0] rand_bmp();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 16'hD7FF));
		return 16'($urandom_range(16'hE000, 16'hFFFF));
	endfunction

	function automatic logic [15:0] rand_high();
		return {6'b110110, 10'($urandom_range(0, 1023))};
	endfunction

	// string of random units, marks, lone and broken surrogates, sometimes with a broken tail
	task automatic gen_string();
		int         n;
		int         tail;
		bit         close;
		logic [19:0] off;
		logic        be;
		unit_kind_e kind;
		str_bytes.delete();
		if ($urandom_range(0, 3) == 0) begin
			be = 1'($urandom_range(0, 1));
			put_mark(be);
			gen_be = be;
		end
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			kind = unit_kind_e'($urandom_range(0, 5));
			case (kind)
				K_ASCII: put_unit(16'($urandom_range(0, 127)));
				K_BMP: put_unit(rand_bmp());
				K_PAIR: begin
					off = 20'($urandom_range(0, 20'hFFFFF));
					put_unit({6'b110110, off[19:10]});
					put_unit({6'b110111, off[9:0]});
				end
				K_LONE_LOW: put_unit({6'b110111, 10'($urandom_range(0, 1023))});
				K_BROKEN: begin
					put_unit(rand_high());
					case ($urandom_range(0, 3))
						0: put_unit(16'($urandom_range(0, 127)));
						1: put_unit(rand_bmp());
						2: put_unit(rand_high());
						default: put_mark(1'($urandom_range(0, 1)));
					endcase
				end
				K_MARK: begin
					be = 1'($urandom_range(0, 1));
					put_mark(be);
					gen_be = be;
				end
				default: put_unit(16'h0000);
			endcase
		end
		tail = $urandom_range(0, 7);
		if (tail == 0)
			str_bytes.push_back(8'($urandom_range(0, 255)));
		else if (tail == 1)
			put_unit(rand_high());
		close = (tail != 7);
		for (int i = 0; i < str_bytes.size(); i++)
			queue_byte(str_bytes[i], close && i == str_bytes.size() - 1);
	endtask

	task automatic gen_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (drv_busy || byte_backlog.size() != 0 || cp_expected.size() != 0);
		// marks and held surrogates can still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_order(input logic be);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_value <= be;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
		ord_be = be;
	endtask

	initial begin
		int   queued;
		logic be;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIRECTED; i++)
			queue_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		queue_byte(8'($urandom_range(0, 255)), 1'b1);
		for (int ph = 1; ph < N_PHASES; ph++) begin
			wait_drained();
			case (ph)
				1, 3: be = 1'b0;
				2, 4: be = 1'b1;
				default: be = 1'($urandom_range(0, 1));
			endcase
			write_default_order(be);
			gen_be = be;
			send_idle_on = (ph == 1 || ph == 4);
			recv_idle_on = (ph == 1 || ph == 2 || ph == 5);
			// stall the output while the input keeps streaming
			if (ph == 2)
				hold_req = 1'b1;
			queued = byte_backlog.size();
			while (byte_backlog.size() - queued < PHASE_BYTES) begin
				if ($urandom_range(0, 7) == 0)
					gen_noise();
				else
					gen_string();
			end
			// end the phase with no partial unit left
			queue_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && cp_expected.size() == 0)
			$display("utf16_byte_stream_decoder verification clean");
		else
			$display("utf16_byte_stream_decoder verification failed");
		$finish;
	end

endmodule

>>> sim.f
sv/ubsd_pkg.sv
sv/ubsd_if.sv
sv/ubsd_front.sv
sv/ubsd_queue.sv
sv/ubsd_back.sv
sv/utf16_byte_stream_decoder.sv
tb/utf16_byte_stream_decoder_tb.sv
